@@ hw/rtl/dq_pkg.sv @@
// Shared constants, types and helpers for the double-ended queue.
`default_nettype none
package dq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int IDX_W      = 6;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_FRONT = 3'd4,
      OP_READ_BACK  = 3'd5,
      OP_READ_INDEX = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } state_type;

   // Circular position: base + offset modulo DEPTH, offset below DEPTH.
   function automatic logic [ADDR_W-1:0] wrap_pos(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dq_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/double_ended_queue_top.sv @@
// Top level of the double-ended queue: control, pointers and item store.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_type selects push front/back, pop front/back, read front/back,
//   read at req_read_index (counted from the front) or clear.
//   Each transaction gives exactly one result: rsp_strobe is high for one
//   cycle with rsp_read_data, rsp_item_count (count after the transaction)
//   and rsp_status (ok, empty, index out of range, full).
//   Timing: the accept edge sets state_ff to ST_RESP, and strobe_ff then
//   raises the result strobe. busy is high for one cycle after each accept,
//   so no new transaction is taken while one is in ST_RESP; the item store
//   is read or written in the accept cycle, and its registered read data
//   is registered into the result in the next.
//   The receiver cannot stall; results are always delivered.
//   Reset empties the queue (head and count to zero). The store contents
//   are not cleared and need not be, as only pushed entries are ever read.
`default_nettype none
module double_ended_queue_top
   import dq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [2:0]            req_type,
   input  wire logic [DATA_WIDTH-1:0] req_push_data,
   input  wire logic [IDX_W-1:0]      req_read_index,
   output logic                       rsp_strobe,
   output logic [DATA_WIDTH-1:0]      rsp_read_data,
   output logic [CNT_W-1:0]           rsp_item_count,
   output logic [1:0]                 rsp_status
);

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   status_type            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  strobe_ff;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [CNT_W-1:0]      rcount_ff;
   status_type            rstatus_ff;

   logic                  accept;
   logic                  is_full;
   logic                  is_empty;
   op_type                op;
   logic                  mem_en;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   assign op       = op_type'(req_type);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      busy   = 1'b0;
      accept = 1'b0;
      case (state_ff)
         ST_IDLE: accept = start;
         ST_RESP: busy   = 1'b1;
         default: busy   = 1'b0;
      endcase
   end

   // request decode: pointer update and store access in the accept cycle
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = head_ff;
      if (accept) begin
         status_in = STATUS_OK;
         rd_ok_in  = 1'b0;
         case (op)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  head_in  = wrap_pos(head_ff, CNT_W'(DEPTH - 1));
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = head_in;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = wrap_pos(head_ff, count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  head_in  = wrap_pos(head_ff, CNT_W'(1));
                  count_in = count_ff - 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_READ_FRONT: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  mem_en   = 1'b1;
                  mem_addr = head_ff;
                  rd_ok_in = 1'b1;
               end
            end
            OP_READ_BACK: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  mem_en   = 1'b1;
                  mem_addr = wrap_pos(head_ff, count_ff - 1'b1);
                  rd_ok_in = 1'b1;
               end
            end
            OP_READ_INDEX: begin
               if (CNT_W'(req_read_index) >= count_ff) begin
                  status_in = STATUS_RANGE;
               end else begin
                  mem_en   = 1'b1;
                  mem_addr = wrap_pos(head_ff, CNT_W'(req_read_index));
                  rd_ok_in = 1'b1;
               end
            end
            OP_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: status_in = STATUS_OK;
         endcase
      end
   end

   dq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (req_push_data),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= (state_ff == ST_RESP);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
      if (state_ff == ST_RESP) begin
         rdata_ff   <= rd_ok_ff ? mem_rdata : '0;
         rcount_ff  <= count_ff;
         rstatus_ff <= status_ff;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_read_data  = rdata_ff;
   assign rsp_item_count = rcount_ff;
   assign rsp_status     = rstatus_ff;

   // every accepted transaction yields a result strobe
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("item count beyond store depth");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_FULL) |-> rsp_item_count == CNT_W'(DEPTH))
      else $error("full status with queue not full");

   a_flag_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> rsp_read_data == '0)
      else $error("flagged transaction returned data");

endmodule
`default_nettype wire
